/* rtl/sarsa_pkg.sv */
// ----------------------------------------------------------------------------
// SARSA(lambda) engine package
// Operation and register codes, reset values and the Q16.16 rounding and
// saturation helpers used by the table engine.
// ----------------------------------------------------------------------------
package sarsa_pkg;

   // Operation codes carried by one request beat.
   localparam logic [1:0] OP_CHOOSE = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [1:0] REG_ALPHA   = 2'd0;
   localparam logic [1:0] REG_GAMMA   = 2'd1;
   localparam logic [1:0] REG_LAMBDA  = 2'd2;
   localparam logic [1:0] REG_EPSILON = 2'd3;

   // Reset values of the rate registers (unsigned 0.16 fractions).
   localparam logic [15:0] RESET_ALPHA   = 16'd26214;
   localparam logic [15:0] RESET_GAMMA   = 16'd64881;
   localparam logic [15:0] RESET_LAMBDA  = 16'd58982;
   localparam logic [15:0] RESET_EPSILON = 16'd1311;

   localparam int CSR_ADDR_WIDTH = 4;

   // Round a product carrying 16 fraction bits to nearest, halves upward.
   function automatic logic signed [63:0] round_q16(input logic signed [63:0] p);
      return (p + 64'sd32768) >>> 16;
   endfunction

   // Clamp to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/sarsa_lambda_q_table_engine.sv */
// ----------------------------------------------------------------------------
// SARSA(lambda) Q table engine
// An update sweeps over both tables at one entry per cycle.
// One item at a time; busy drops in the cycle of the one-cycle rsp_valid
//   pulse, which the receiver cannot stall.
// Reset: both tables are cleared, one entry per cycle, with busy high;
//   CSR writes still land.
// ----------------------------------------------------------------------------
module sarsa_lambda_q_table_engine
   import sarsa_pkg::*;
#(
   parameter int NUM_STATES  = 4096,
   parameter int NUM_ACTIONS = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_op,
   input  logic [11:0]               req_cur_state,
   input  logic [1:0]                req_cur_action,
   input  logic [11:0]               req_next_state,
   input  logic [1:0]                req_next_action,
   input  logic signed [15:0]        req_reward,
   input  logic [15:0]               req_explore_draw,
   input  logic [1:0]                req_random_action,
   // Result channel.
   output logic                      rsp_valid,
   output logic [1:0]                rsp_chosen_action,
   output logic                      rsp_explored,
   // Configuration port.
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
   localparam int IW    = $clog2(DEPTH);
   localparam int SW    = $clog2(NUM_STATES);
   localparam int AW    = $clog2(NUM_ACTIONS);

   localparam logic [3:0] ST_INIT     = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_CH_RD    = 4'd2;
   localparam logic [3:0] ST_CH_CMP   = 4'd3;
   localparam logic [3:0] ST_UP_RDN   = 4'd4;
   localparam logic [3:0] ST_UP_RDC   = 4'd5;
   localparam logic [3:0] ST_UP_DELTA = 4'd6;
   localparam logic [3:0] ST_UP_STEP  = 4'd7;
   localparam logic [3:0] ST_UP_ROUND = 4'd8;
   localparam logic [3:0] ST_SWEEP    = 4'd9;
   localparam logic [3:0] ST_CLEAR    = 4'd10;

   // Control registers.
   logic [3:0]  state_ff, state_in;
   logic [IW:0] cnt_ff, cnt_in;
   logic [AW-1:0] act_ff, act_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s3_valid_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] alpha_ff, gamma_ff, lambda_ff, eps_ff;

   // Payload registers.
   logic [IW-1:0] base_ff, base_in, ci_ff, ci_in, ni_ff, ni_in;
   logic signed [15:0] rew_ff, rew_in;
   logic [AW-1:0] best_a_ff, best_a_in;
   logic signed [31:0] best_q_ff, best_q_in;
   logic [31:0] gl_prod_ff, gl_prod_in;
   logic [15:0] gl_ff, gl_in;
   logic signed [48:0] gq_prod_ff, gq_prod_in;
   logic signed [31:0] delta_ff, delta_in;
   logic signed [48:0] step_prod_ff, step_prod_in;
   logic signed [31:0] step_ff, step_in;
   logic [IW-1:0] s1_addr_ff, s1_addr_in, s2_addr_ff, s3_addr_ff;
   logic signed [63:0] prod_qe_ff, prod_qe_in;
   logic signed [48:0] prod_ee_ff, prod_ee_in;
   logic signed [31:0] q2_ff, q3_ff, enew_ff, enew_in;
   logic signed [47:0] inc_ff, inc_in;
   logic [1:0] rsp_action_ff, rsp_action_in;
   logic rsp_explored_ff, rsp_explored_in;

   // Memory ports.
   logic q_we, e_we;
   logic [IW-1:0] q_waddr, e_waddr, q_raddr, e_raddr;
   logic [31:0] q_wdata, e_wdata, q_rdata, e_rdata;
   logic signed [31:0] q_rd, e_rd;

   logic accept, csr_write;
   logic [SW-1:0] cs_cl, ns_cl;
   logic [AW-1:0] ca_cl, na_cl, ra_cl;
   logic [IW-1:0] cnt_idx;
   logic take_new;
   logic signed [63:0] delta_sum, rnd_qe, rnd_ee, rnd_gq, rnd_step, q_sum;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign cnt_idx   = cnt_ff[IW-1:0];
   assign q_rd      = $signed(q_rdata);
   assign e_rd      = $signed(e_rdata);
   assign csr_write = psel && penable && pwrite && pready;

   // Clamp request indexes to the table range.
   assign cs_cl = (32'(req_cur_state) >= NUM_STATES) ? SW'(NUM_STATES - 1)
                                                     : SW'(req_cur_state);
   assign ns_cl = (32'(req_next_state) >= NUM_STATES) ? SW'(NUM_STATES - 1)
                                                      : SW'(req_next_state);
   assign ca_cl = (32'(req_cur_action) >= NUM_ACTIONS) ? AW'(NUM_ACTIONS - 1)
                                                       : AW'(req_cur_action);
   assign na_cl = (32'(req_next_action) >= NUM_ACTIONS) ? AW'(NUM_ACTIONS - 1)
                                                        : AW'(req_next_action);
   assign ra_cl = (32'(req_random_action) >= NUM_ACTIONS) ? AW'(NUM_ACTIONS - 1)
                                                          : AW'(req_random_action);

   // Action-value and trace tables.
   sarsa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_q_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   sarsa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_e_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (e_raddr),
      .rdata (e_rdata)
   );

   // Sequencer: op dispatch, choose scan, update prologue and sweeps.
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      act_in          = act_ff;
      s1_valid_in     = 1'b0;
      s1_addr_in      = cnt_idx;
      rsp_valid_in    = 1'b0;
      rsp_action_in   = rsp_action_ff;
      rsp_explored_in = rsp_explored_ff;
      base_in         = base_ff;
      ci_in           = ci_ff;
      ni_in           = ni_ff;
      rew_in          = rew_ff;
      best_a_in       = best_a_ff;
      best_q_in       = best_q_ff;
      gl_prod_in      = gl_prod_ff;
      gl_in           = gl_ff;
      gq_prod_in      = gq_prod_ff;
      delta_in        = delta_ff;
      step_prod_in    = step_prod_ff;
      step_in         = step_ff;
      q_we            = 1'b0;
      q_waddr         = cnt_idx;
      q_wdata         = '0;
      e_we            = 1'b0;
      e_waddr         = cnt_idx;
      e_wdata         = '0;
      q_raddr         = cnt_idx;
      e_raddr         = cnt_idx;
      take_new        = 1'b0;
      rnd_gq          = round_q16(64'(gq_prod_ff));
      rnd_step        = round_q16(64'(step_prod_ff));
      delta_sum       = (64'(rew_ff) <<< 16) + rnd_gq - 64'(q_rd);

      unique case (state_ff)
         ST_INIT: begin
            q_we   = 1'b1;
            e_we   = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (IW+1)'(DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_CHOOSE: begin
                     if (req_explore_draw < eps_ff) begin
                        rsp_valid_in    = 1'b1;
                        rsp_action_in   = 2'(ra_cl);
                        rsp_explored_in = 1'b1;
                     end else begin
                        base_in  = IW'(cs_cl) * IW'(NUM_ACTIONS);
                        act_in   = '0;
                        state_in = ST_CH_RD;
                     end
                  end
                  OP_UPDATE: begin
                     ci_in    = IW'(cs_cl) * IW'(NUM_ACTIONS) + IW'(ca_cl);
                     ni_in    = IW'(ns_cl) * IW'(NUM_ACTIONS) + IW'(na_cl);
                     rew_in   = req_reward;
                     state_in = ST_UP_RDN;
                  end
                  OP_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     rsp_valid_in    = 1'b1;
                     rsp_action_in   = '0;
                     rsp_explored_in = 1'b0;
                  end
               endcase
            end
         end
         ST_CH_RD: begin
            q_raddr  = base_ff + IW'(act_ff);
            state_in = ST_CH_CMP;
         end
         ST_CH_CMP: begin
            // The first action seeds the running max; later ones win only if strictly greater.
            take_new = (act_ff == '0) || (q_rd > best_q_ff);
            if (take_new) begin
               best_a_in = act_ff;
               best_q_in = q_rd;
            end
            if (act_ff == AW'(NUM_ACTIONS - 1)) begin
               rsp_valid_in    = 1'b1;
               rsp_action_in   = take_new ? 2'(act_ff) : 2'(best_a_ff);
               rsp_explored_in = 1'b0;
               state_in        = ST_IDLE;
            end else begin
               act_in   = act_ff + 1'b1;
               state_in = ST_CH_RD;
            end
         end
         ST_UP_RDN: begin
            q_raddr    = ni_ff;
            gl_prod_in = gamma_ff * lambda_ff;
            state_in   = ST_UP_RDC;
         end
         ST_UP_RDC: begin
            q_raddr    = ci_ff;
            e_raddr    = ci_ff;
            gq_prod_in = $signed({1'b0, gamma_ff}) * q_rd;
            gl_in      = 16'((33'(gl_prod_ff) + 33'd32768) >> 16);
            state_in   = ST_UP_DELTA;
         end
         ST_UP_DELTA: begin
            // TD error, and the accumulating trace bump on the current entry.
            delta_in = sat32(delta_sum);
            e_we     = 1'b1;
            e_waddr  = ci_ff;
            e_wdata  = sat32(64'(e_rd) + 64'sd65536);
            state_in = ST_UP_STEP;
         end
         ST_UP_STEP: begin
            step_prod_in = $signed({1'b0, alpha_ff}) * delta_ff;
            state_in     = ST_UP_ROUND;
         end
         ST_UP_ROUND: begin
            step_in  = rnd_step[31:0];
            cnt_in   = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (cnt_ff < (IW+1)'(DEPTH)) begin
               s1_valid_in = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end else if (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_action_in   = '0;
               rsp_explored_in = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            e_we   = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (IW+1)'(DEPTH - 1)) begin
               rsp_valid_in    = 1'b1;
               rsp_action_in   = '0;
               rsp_explored_in = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Sweep write-back stage owns both write ports while it is active.
      if (s3_valid_ff) begin
         q_sum   = 64'(q3_ff) + 64'(inc_ff);
         q_we    = 1'b1;
         q_waddr = s3_addr_ff;
         q_wdata = sat32(q_sum);
         e_we    = 1'b1;
         e_waddr = s3_addr_ff;
         e_wdata = enew_ff;
      end else begin
         q_sum = '0;
      end
   end

   // Sweep datapath: products, then rounding, then accumulate and write.
   always_comb begin
      prod_qe_in = step_ff * e_rd;
      prod_ee_in = e_rd * $signed({1'b0, gl_ff});
      rnd_qe     = round_q16(prod_qe_ff);
      rnd_ee     = round_q16(64'(prod_ee_ff));
      inc_in     = rnd_qe[47:0];
      enew_in    = sat32(rnd_ee);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         act_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         act_ff       <= act_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      base_ff         <= base_in;
      ci_ff           <= ci_in;
      ni_ff           <= ni_in;
      rew_ff          <= rew_in;
      best_a_ff       <= best_a_in;
      best_q_ff       <= best_q_in;
      gl_prod_ff      <= gl_prod_in;
      gl_ff           <= gl_in;
      gq_prod_ff      <= gq_prod_in;
      delta_ff        <= delta_in;
      step_prod_ff    <= step_prod_in;
      step_ff         <= step_in;
      s1_addr_ff      <= s1_addr_in;
      s2_addr_ff      <= s1_addr_ff;
      s3_addr_ff      <= s2_addr_ff;
      prod_qe_ff      <= prod_qe_in;
      prod_ee_ff      <= prod_ee_in;
      q2_ff           <= q_rd;
      q3_ff           <= q2_ff;
      inc_ff          <= inc_in;
      enew_ff         <= enew_in;
      rsp_action_ff   <= rsp_action_in;
      rsp_explored_ff <= rsp_explored_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= RESET_ALPHA;
         gamma_ff  <= RESET_GAMMA;
         lambda_ff <= RESET_LAMBDA;
         eps_ff    <= RESET_EPSILON;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_ALPHA:   alpha_ff  <= pwdata[15:0];
            REG_GAMMA:   gamma_ff  <= pwdata[15:0];
            REG_LAMBDA:  lambda_ff <= pwdata[15:0];
            REG_EPSILON: eps_ff    <= pwdata[15:0];
            default:     alpha_ff  <= alpha_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (paddr[3:2])
         REG_ALPHA:   prdata = {16'd0, alpha_ff};
         REG_GAMMA:   prdata = {16'd0, gamma_ff};
         REG_LAMBDA:  prdata = {16'd0, lambda_ff};
         REG_EPSILON: prdata = {16'd0, eps_ff};
         default:     prdata = '0;
      endcase
   end

   assign pready            = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_action = rsp_action_ff;
   assign rsp_explored      = rsp_explored_ff;

`ifndef SYNTHESIS
   // The table clearing pass holds off requests right after reset.
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   // Nothing writes the tables while the block is idle.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!q_we && !e_we))
      else $error("table write while idle");

   // A result beat follows either work in progress or an accepted request.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result beat without a request");

   // The sweep write-back stage only runs inside an update sweep.
   a_wb_in_sweep: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (state_ff == ST_SWEEP))
      else $error("sweep write-back outside the sweep");
`endif

endmodule

/* rtl/sarsa_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sarsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* bench/tb_sarsa_lambda_q_table_engine.sv */
// ----------------------------------------------------------------------------
// SARSA(lambda) Q table engine testbench
// Sends choose, update, clear and no-op beats to the engine while it keeps its
// own copy of the Q and trace tables. That copy predicts every result beat.
// Each result is checked field by field. The rate registers are set to several
// values, extremes included, and each value is read back.
// ----------------------------------------------------------------------------
module tb_sarsa_lambda_q_table_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import sarsa_pkg::*;

   localparam int STATES       = 4096;
   localparam int ACTIONS      = 3;
   localparam int TABLE_DEPTH  = STATES * ACTIONS;
   localparam int CYCLE_LIMIT  = 8_000_000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [1:0]         op;
      logic [11:0]        cur_state;
      logic [1:0]         cur_action;
      logic [11:0]        next_state;
      logic [1:0]         next_action;
      logic signed [15:0] reward;
      logic [15:0]        explore_draw;
      logic [1:0]         random_action;
   } sarsa_request_type;

   typedef struct {
      logic [1:0] action;
      logic       explored;
   } choice_type;

   // Clock, reset and every input of the engine start at known values.
   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      start             = 1'b0;
   logic                      busy;
   logic [1:0]                req_op            = OP_NOP;
   logic [11:0]               req_cur_state     = '0;
   logic [1:0]                req_cur_action    = '0;
   logic [11:0]               req_next_state    = '0;
   logic [1:0]                req_next_action   = '0;
   logic signed [15:0]        req_reward        = '0;
   logic [15:0]               req_explore_draw  = '0;
   logic [1:0]                req_random_action = '0;
   logic                      rsp_valid;
   logic [1:0]                rsp_chosen_action;
   logic                      rsp_explored;
   logic                      psel              = 1'b0;
   logic                      penable           = 1'b0;
   logic                      pwrite            = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr             = '0;
   logic [31:0]               pwdata            = '0;
   logic [31:0]               prdata;
   logic                      pready;

   // Predicted engine state: both tables and the four rates.
   logic signed [31:0] q_values [TABLE_DEPTH];
   logic signed [31:0] traces [TABLE_DEPTH];
   logic [15:0]        alpha_rate;
   logic [15:0]        gamma_rate;
   logic [15:0]        lambda_rate;
   logic [15:0]        epsilon_rate;

   sarsa_request_type action_requests[$];
   choice_type        expected_choices[$];

   bit sender_idles  = 1'b1;
   int error_count   = 0;
   int cycle_count   = 0;
   int choose_beats  = 0;
   int update_beats  = 0;
   int clear_beats   = 0;
   int nop_beats     = 0;
   int explore_beats = 0;
   int rate_writes   = 0;

   sarsa_lambda_q_table_engine #(
      .NUM_STATES (STATES),
      .NUM_ACTIONS(ACTIONS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_cur_state    (req_cur_state),
      .req_cur_action   (req_cur_action),
      .req_next_state   (req_next_state),
      .req_next_action  (req_next_action),
      .req_reward       (req_reward),
      .req_explore_draw (req_explore_draw),
      .req_random_action(req_random_action),
      .rsp_valid        (rsp_valid),
      .rsp_chosen_action(rsp_chosen_action),
      .rsp_explored     (rsp_explored),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #4 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // Product with 16 fraction bits, rounded to nearest with halves upward.
   function automatic logic signed [63:0] round_fraction(input logic signed [63:0] product);
      logic signed [63:0] biased;
      biased = product + 64'sd32768;
      if (biased >= 0) begin
         return biased / 64'sd65536;
      end
      return -((-biased + 64'sd65535) / 64'sd65536);
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic int unsigned state_index(input logic [11:0] s);
      return (s >= STATES) ? STATES - 1 : int'(s);
   endfunction

   function automatic int unsigned action_index(input logic [1:0] a);
      return (a >= ACTIONS) ? ACTIONS - 1 : int'(a);
   endfunction

   // Works out the answer to one request and advances the predicted tables.
   function automatic choice_type predict_sarsa_step(input sarsa_request_type r);
      choice_type         answer;
      int unsigned        row;
      int unsigned        best;
      int unsigned        cur_idx;
      int unsigned        next_idx;
      logic signed [63:0] reward_q;
      logic signed [63:0] gamma_q;
      logic signed [63:0] step_q;
      logic signed [63:0] decay;
      logic signed [63:0] tr;
      logic signed [31:0] delta;
      answer.action   = 2'd0;
      answer.explored = 1'b0;
      case (r.op)
         OP_CHOOSE: begin
            if (r.explore_draw < epsilon_rate) begin
               answer.action   = 2'(action_index(r.random_action));
               answer.explored = 1'b1;
            end else begin
               // Greedy pick; only a strictly larger value displaces the
               // lower index.
               row  = state_index(r.cur_state) * ACTIONS;
               best = 0;
               for (int a = 1; a < ACTIONS; a++) begin
                  if (q_values[row + a] > q_values[row + best]) begin
                     best = a;
                  end
               end
               answer.action = 2'(best);
            end
         end
         OP_UPDATE: begin
            cur_idx  = state_index(r.cur_state) * ACTIONS + action_index(r.cur_action);
            next_idx = state_index(r.next_state) * ACTIONS + action_index(r.next_action);
            reward_q = r.reward;
            gamma_q  = round_fraction($signed({48'd0, gamma_rate}) * q_values[next_idx]);
            delta    = clip32((reward_q <<< 16) + gamma_q - q_values[cur_idx]);
            step_q   = round_fraction($signed({48'd0, alpha_rate}) * delta);
            decay    = ({48'd0, gamma_rate} * {48'd0, lambda_rate} + 64'd32768) >> 16;
            traces[cur_idx] = clip32(traces[cur_idx] + 64'sd65536);
            // Sweep: entries with a zero trace stay as they are.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               tr = traces[i];
               if (tr != 0) begin
                  q_values[i] = clip32(q_values[i] + round_fraction(step_q * tr));
                  traces[i]   = clip32(round_fraction(tr * decay));
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               traces[i] = '0;
            end
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   // Request driver: presents the oldest queued request, idling at random while sender_idles is set.
   always @(negedge clock) begin
      if (reset || action_requests.size() == 0) begin
         start <= 1'b0;
      end else begin
         start             <= !(sender_idles && $urandom_range(99) < 23);
         req_op            <= action_requests[0].op;
         req_cur_state     <= action_requests[0].cur_state;
         req_cur_action    <= action_requests[0].cur_action;
         req_next_state    <= action_requests[0].next_state;
         req_next_action   <= action_requests[0].next_action;
         req_reward        <= action_requests[0].reward;
         req_explore_draw  <= action_requests[0].explore_draw;
         req_random_action <= action_requests[0].random_action;
      end
   end

   // Monitor: register accesses, result beats and request beats.
   always @(posedge clock) begin : monitor
      sarsa_request_type seen;
      choice_type        want;
      logic [15:0]       rate_now;
      if (!reset) begin
         // A register access completes in its access cycle.
         if (psel && penable && pready) begin
            case (paddr[3:2])
               REG_ALPHA:   rate_now = alpha_rate;
               REG_GAMMA:   rate_now = gamma_rate;
               REG_LAMBDA:  rate_now = lambda_rate;
               default:     rate_now = epsilon_rate;
            endcase
            if (pwrite) begin
               rate_writes++;
               case (paddr[3:2])
                  REG_ALPHA:   alpha_rate   = pwdata[15:0];
                  REG_GAMMA:   gamma_rate   = pwdata[15:0];
                  REG_LAMBDA:  lambda_rate  = pwdata[15:0];
                  default:     epsilon_rate = pwdata[15:0];
               endcase
            end else if (prdata[15:0] !== rate_now) begin
               error_count++;
               $display("%0t: rate register %0d read expected %0d actual %0d",
                        $time, paddr[3:2], rate_now, prdata[15:0]);
            end
         end

         // Result beat against the oldest expectation.
         if (rsp_valid) begin
            if (expected_choices.size() == 0) begin
               error_count++;
               $display("%0t: result beat expected none actual action %0d explored %0d",
                        $time, rsp_chosen_action, rsp_explored);
            end else begin
               want = expected_choices.pop_front();
               if (rsp_chosen_action !== want.action) begin
                  error_count++;
                  $display("%0t: chosen_action expected %0d actual %0d",
                           $time, want.action, rsp_chosen_action);
               end
               if (rsp_explored !== want.explored) begin
                  error_count++;
                  $display("%0t: explored expected %0d actual %0d",
                           $time, want.explored, rsp_explored);
               end
            end
         end

         // Request beat: predict from what the engine actually saw.
         if (start && !busy) begin
            seen.op            = req_op;
            seen.cur_state     = req_cur_state;
            seen.cur_action    = req_cur_action;
            seen.next_state    = req_next_state;
            seen.next_action   = req_next_action;
            seen.reward        = req_reward;
            seen.explore_draw  = req_explore_draw;
            seen.random_action = req_random_action;
            want = predict_sarsa_step(seen);
            expected_choices.push_back(want);
            if (action_requests.size() != 0) begin
               void'(action_requests.pop_front());
            end
            case (seen.op)
               OP_CHOOSE: choose_beats++;
               OP_UPDATE: update_beats++;
               OP_CLEAR:  clear_beats++;
               default:   nop_beats++;
            endcase
            if (want.explored) begin
               explore_beats++;
            end
         end
      end
   end

   // One register access: setup cycle, then access cycle until pready.
   task automatic csr_cycle(input bit is_write, input logic [1:0] idx,
                            input logic [15:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Writes all four rates, then reads each back.
   task automatic set_rates(input logic [15:0] alpha, input logic [15:0] gamma,
                            input logic [15:0] lambda, input logic [15:0] epsilon);
      csr_cycle(1'b1, REG_ALPHA, alpha);
      csr_cycle(1'b1, REG_GAMMA, gamma);
      csr_cycle(1'b1, REG_LAMBDA, lambda);
      csr_cycle(1'b1, REG_EPSILON, epsilon);
      csr_cycle(1'b0, REG_ALPHA, 16'd0);
      csr_cycle(1'b0, REG_GAMMA, 16'd0);
      csr_cycle(1'b0, REG_LAMBDA, 16'd0);
      csr_cycle(1'b0, REG_EPSILON, 16'd0);
   endtask

   // Holds the sender until every queued request has been answered.
   task automatic wait_for_drain();
      while (action_requests.size() != 0 || expected_choices.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic sarsa_request_type make_request(
      input logic [1:0] op, input logic [11:0] cs, input logic [1:0] ca,
      input logic [11:0] ns, input logic [1:0] na, input logic signed [15:0] rw,
      input logic [15:0] draw, input logic [1:0] ra);
      sarsa_request_type r;
      r.op            = op;
      r.cur_state     = cs;
      r.cur_action    = ca;
      r.next_state    = ns;
      r.next_action   = na;
      r.reward        = rw;
      r.explore_draw  = draw;
      r.random_action = ra;
      return r;
   endfunction

   // Mostly a handful of states so that values build up; sometimes any state.
   function automatic logic [11:0] pick_state();
      if ($urandom_range(99) < 30) begin
         return 12'($urandom);
      end
      if ($urandom_range(99) < 20) begin
         return 12'(STATES - 1 - $urandom_range(1));
      end
      return 12'($urandom_range(3));
   endfunction

   // Mostly legal actions, now and then the out-of-range code.
   function automatic logic [1:0] pick_action();
      if ($urandom_range(9) == 0) begin
         return 2'd3;
      end
      return 2'($urandom_range(ACTIONS - 1));
   endfunction

   function automatic logic signed [15:0] pick_reward();
      if ($urandom_range(99) < 25) begin
         return 16'($urandom);
      end
      return 16'(int'($urandom_range(40)) - 20);
   endfunction

   // Draws spread over the whole range, the low end and the epsilon threshold.
   function automatic logic [15:0] pick_draw();
      case ($urandom_range(3))
         0:       return 16'($urandom_range(2047));
         1:       return epsilon_rate + 16'($urandom_range(3)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sarsa_request_type random_request(input logic [1:0] op);
      return make_request(op, pick_state(), pick_action(), pick_state(), pick_action(),
                          pick_reward(), pick_draw(), pick_action());
   endfunction

   // Random traffic: mostly episodes (choose in a state, then update toward the
   // next state), the rest uniformly random beats of any kind.
   task automatic queue_random_traffic(input int count);
      int                added;
      logic [11:0]       here;
      logic [11:0]       there;
      sarsa_request_type r;
      added = 0;
      while (added < count) begin
         if ($urandom_range(99) < 25) begin
            r = make_request(2'($urandom), 12'($urandom), 2'($urandom), 12'($urandom),
                             2'($urandom), 16'($urandom), 16'($urandom), 2'($urandom));
            action_requests.push_back(r);
            added++;
         end else begin
            here = pick_state();
            repeat ($urandom_range(2, 5)) begin
               r = random_request(OP_CHOOSE);
               r.cur_state = here;
               action_requests.push_back(r);
               added++;
               there = pick_state();
               if ($urandom_range(99) < 60) begin
                  r = random_request(OP_UPDATE);
                  r.cur_state  = here;
                  r.next_state = there;
                  action_requests.push_back(r);
                  added++;
               end
               here = there;
            end
            // An episode sometimes ends with its traces wiped.
            if ($urandom_range(99) < 20) begin
               action_requests.push_back(random_request(OP_CLEAR));
               added++;
            end
         end
      end
   endtask

   // Stimulus sequence.
   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         q_values[i] = '0;
         traces[i]   = '0;
      end
      alpha_rate   = RESET_ALPHA;
      gamma_rate   = RESET_GAMMA;
      lambda_rate  = RESET_LAMBDA;
      epsilon_rate = RESET_EPSILON;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Reset values of the rates read back.
      csr_cycle(1'b0, REG_ALPHA, 16'd0);
      csr_cycle(1'b0, REG_GAMMA, 16'd0);
      csr_cycle(1'b0, REG_LAMBDA, 16'd0);
      csr_cycle(1'b0, REG_EPSILON, 16'd0);

      // Reset rates: ties, the explore threshold, clamped actions, extreme
      // rewards and states, clear and the unused op.
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'hffff, 2'd0));
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd3, 12'hfff, 2'd3,
                                             16'sh7fff, 16'd0, 2'd3));
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'd1310, 2'd1));
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'd1311, 2'd1));
      action_requests.push_back(make_request(OP_UPDATE, 12'd0, 2'd1, 12'd0, 2'd3,
                                             16'sh7fff, 16'd0, 2'd0));
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'hffff, 2'd0));
      action_requests.push_back(make_request(OP_UPDATE, 12'hfff, 2'd3, 12'hfff, 2'd0,
                                             -16'sd32768, 16'hffff, 2'd3));
      action_requests.push_back(make_request(OP_CHOOSE, 12'hfff, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'hffff, 2'd0));
      action_requests.push_back(make_request(OP_UPDATE, 12'd0, 2'd0, 12'hfff, 2'd2,
                                             16'sd0, 16'd0, 2'd0));
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'hffff, 2'd0));
      action_requests.push_back(make_request(OP_CLEAR, 12'hfff, 2'd3, 12'hfff, 2'd3,
                                             -16'sd1, 16'd0, 2'd3));
      action_requests.push_back(make_request(OP_NOP, 12'hfff, 2'd3, 12'hfff, 2'd3,
                                             -16'sd1, 16'd0, 2'd3));
      action_requests.push_back(make_request(OP_UPDATE, 12'd1, 2'd2, 12'd0, 2'd1,
                                             -16'sd1, 16'hffff, 2'd0));
      action_requests.push_back(make_request(OP_CHOOSE, 12'd1, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'hffff, 2'd0));
      wait_for_drain();

      // Full-scale rates with zero epsilon; the sender never idles here.
      set_rates(16'hffff, 16'hffff, 16'hffff, 16'd0);
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'd0, 2'd2));
      action_requests.push_back(make_request(OP_UPDATE, 12'd0, 2'd1, 12'd1, 2'd2,
                                             16'sh7fff, 16'd0, 2'd0));
      action_requests.push_back(make_request(OP_UPDATE, 12'd0, 2'd1, 12'd0, 2'd1,
                                             -16'sd32768, 16'd0, 2'd0));
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'd0, 2'd1));
      sender_idles = 1'b0;
      queue_random_traffic(25);
      wait_for_drain();
      sender_idles = 1'b1;

      // Zero rates with full epsilon: every draw but the top one explores.
      set_rates(16'd0, 16'd0, 16'd0, 16'hffff);
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'hffff, 2'd1));
      action_requests.push_back(make_request(OP_CHOOSE, 12'd0, 2'd0, 12'd0, 2'd0,
                                             16'sd0, 16'hfffe, 2'd3));
      action_requests.push_back(make_request(OP_UPDATE, 12'd2, 2'd1, 12'd0, 2'd1,
                                             16'sd5, 16'd0, 2'd0));
      queue_random_traffic(25);
      wait_for_drain();

      // Random rates.
      set_rates(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(8191)));
      queue_random_traffic(30);
      wait_for_drain();

      repeat (DRAIN_CYCLES) @(negedge clock);
      error_count += expected_choices.size();

      $display("Run covered %0d choose (%0d explored), %0d update, %0d clear, %0d no-op beats,",
               choose_beats, explore_beats, update_beats, clear_beats, nop_beats);
      $display("over four rate settings with %0d register writes and a read-back of each.",
               rate_writes);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
